// ----- rtl/segint_pkg.sv -----
// Segment intersection: shared widths and the divider pipeline stage type.
// No dependencies.
package segint_pkg;

  localparam int CW   = 16;            // coordinate width
  localparam int DW   = CW + 1;        // coordinate difference
  localparam int PW   = 2 * DW;        // product of two differences
  localparam int DETW = PW + 1;        // signed determinant / numerators
  localparam int UW   = DETW - 1;      // magnitude after sign normalisation
  localparam int QW   = CW + 1;        // quotient bits, one extra for rounding
  localparam int NW   = UW + CW + 1;   // doubled dividend

  typedef struct packed {
    logic          vld;
    logic          hit;
    logic          fix;
    logic [CW-1:0] fx;
    logic [CW-1:0] fy;
    logic [CW-1:0] bax;
    logic [CW-1:0] bay;
    logic          negx;
    logic          negy;
    logic [UW-1:0] det;
    logic [NW-1:0] remx;
    logic [NW-1:0] remy;
    logic [QW-1:0] qx;
    logic [QW-1:0] qy;
  } div_t;

endpackage

// ----- rtl/segment_intersection_top.sv -----
// Segment intersection top level: Cramer determinant, range checks and
// rounded interpolation through a restoring divider pipeline. Uses segint_pkg.
// Throughput: one transaction per cycle; the whole pipeline stalls together
// when the output register holds a transaction that is not taken.
// Reset (rst, synchronous): clears all valid bits; payload is not reset.
module segment_intersection_top (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          s_tvalid,
  output logic                          s_tready,
  // ax, ay, bx, by_coord, cx, cy, dx, dy (16 bits each)
  input  logic [8*segint_pkg::CW-1:0]   s_tdata,
  output logic                          m_tvalid,
  input  logic                          m_tready,
  // px, py (16 bits each)
  output logic [2*segint_pkg::CW-1:0]   m_tdata,
  // hit
  output logic                          m_tuser
);
  import segint_pkg::*;

  logic en;

  logic signed [CW-1:0] ax, ay, bx, by_coord, cx, cy, dx, dy;

  // stage 1: differences
  logic                 v1;
  logic signed [DW-1:0] d_bax, d_bay, d_cdx, d_cdy, d_cax, d_cay;
  logic [CW-1:0]        a1x, a1y, b1x, b1y, c1x, c1y, e1x, e1y;
  // stage 2: products
  logic                 v2;
  logic signed [PW-1:0] p1, p2, p3, p4, p5, p6;
  logic signed [DW-1:0] d2x, d2y;
  logic [CW-1:0]        a2x, a2y, b2x, b2y, c2x, c2y, e2x, e2y;
  // stage 3: determinant and numerators
  logic                   v3;
  logic signed [DETW-1:0] det3, n13, n23;
  logic signed [DW-1:0]   d3x, d3y;
  logic [CW-1:0]          a3x, a3y, b3x, b3y, c3x, c3y, e3x, e3y;
  // stage 4: sign normalised
  logic                   v4;
  logic signed [DETW-1:0] det4, n14, n24;
  logic signed [DW-1:0]   d4x, d4y;
  logic [CW-1:0]          a4x, a4y, b4x, b4y, c4x, c4y, e4x, e4y;
  // stage 5: checks and endpoint choice
  logic          v5, hit5, fix5, negx5, negy5;
  logic [CW-1:0] fx5, fy5, mx5, my5, a5x, a5y;
  logic [UW-1:0] det5, n15;

  div_t dv [QW+1];

  logic          out_vld, out_hit;
  logic [CW-1:0] opx, opy;

  assign en       = !out_vld || m_tready;
  assign s_tready = en;
  assign m_tvalid = out_vld;
  assign m_tuser  = out_hit;
  assign m_tdata  = {opy, opx};

  assign ax       = s_tdata[0*CW +: CW];
  assign ay       = s_tdata[1*CW +: CW];
  assign bx       = s_tdata[2*CW +: CW];
  assign by_coord = s_tdata[3*CW +: CW];
  assign cx       = s_tdata[4*CW +: CW];
  assign cy       = s_tdata[5*CW +: CW];
  assign dx       = s_tdata[6*CW +: CW];
  assign dy       = s_tdata[7*CW +: CW];

  always_ff @(posedge clk) begin
    if (rst) begin
      v1 <= 1'b0;
      v2 <= 1'b0;
      v3 <= 1'b0;
      v4 <= 1'b0;
      v5 <= 1'b0;
    end else if (en) begin
      v1 <= s_tvalid;
      v2 <= v1;
      v3 <= v2;
      v4 <= v3;
      v5 <= v4;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d_bax <= {bx[CW-1], bx} - {ax[CW-1], ax};
      d_bay <= {by_coord[CW-1], by_coord} - {ay[CW-1], ay};
      d_cdx <= {cx[CW-1], cx} - {dx[CW-1], dx};
      d_cdy <= {cy[CW-1], cy} - {dy[CW-1], dy};
      d_cax <= {cx[CW-1], cx} - {ax[CW-1], ax};
      d_cay <= {cy[CW-1], cy} - {ay[CW-1], ay};
      a1x <= ax; a1y <= ay; b1x <= bx; b1y <= by_coord;
      c1x <= cx; c1y <= cy; e1x <= dx; e1y <= dy;

      p1 <= d_bax * d_cdy;
      p2 <= d_cdx * d_bay;
      p3 <= d_cax * d_cdy;
      p4 <= d_cdx * d_cay;
      p5 <= d_bax * d_cay;
      p6 <= d_cax * d_bay;
      d2x <= d_bax; d2y <= d_bay;
      a2x <= a1x; a2y <= a1y; b2x <= b1x; b2y <= b1y;
      c2x <= c1x; c2y <= c1y; e2x <= e1x; e2y <= e1y;

      det3 <= {p1[PW-1], p1} - {p2[PW-1], p2};
      n13  <= {p3[PW-1], p3} - {p4[PW-1], p4};
      n23  <= {p5[PW-1], p5} - {p6[PW-1], p6};
      d3x <= d2x; d3y <= d2y;
      a3x <= a2x; a3y <= a2y; b3x <= b2x; b3y <= b2y;
      c3x <= c2x; c3y <= c2y; e3x <= e2x; e3y <= e2y;

      if (det3[DETW-1]) begin
        det4 <= -det3;
        n14  <= -n13;
        n24  <= -n23;
      end else begin
        det4 <= det3;
        n14  <= n13;
        n24  <= n23;
      end
      d4x <= d3x; d4y <= d3y;
      a4x <= a3x; a4y <= a3y; b4x <= b3x; b4y <= b3y;
      c4x <= c3x; c4y <= c3y; e4x <= e3x; e4y <= e3y;

      hit5 <= (det4 != '0) && !n14[DETW-1] && !n24[DETW-1] &&
              (det4 >= n14) && (det4 >= n24);
      fix5 <= 1'b1;
      if (n14 == '0) begin
        fx5 <= a4x; fy5 <= a4y;
      end else if (n14 == det4) begin
        fx5 <= b4x; fy5 <= b4y;
      end else if (n24 == '0) begin
        fx5 <= c4x; fy5 <= c4y;
      end else if (n24 == det4) begin
        fx5 <= e4x; fy5 <= e4y;
      end else begin
        fix5 <= 1'b0;
        fx5 <= a4x; fy5 <= a4y;
      end
      negx5 <= d4x[DW-1];
      negy5 <= d4y[DW-1];
      mx5   <= d4x[DW-1] ? CW'(-d4x) : CW'(d4x);
      my5   <= d4y[DW-1] ? CW'(-d4y) : CW'(d4y);
      a5x   <= a4x;
      a5y   <= a4y;
      det5  <= det4[UW-1:0];
      n15   <= n14[UW-1:0];
    end
  end

  // stage 6: dividend products, doubled for the rounding bit
  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0].vld <= 1'b0;
    end else if (en) begin
      dv[0].vld <= v5;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      dv[0].hit  <= hit5;
      dv[0].fix  <= fix5;
      dv[0].fx   <= fx5;
      dv[0].fy   <= fy5;
      dv[0].bax  <= a5x;
      dv[0].bay  <= a5y;
      dv[0].negx <= negx5;
      dv[0].negy <= negy5;
      dv[0].det  <= det5;
      dv[0].remx <= {(NW-1)'(n15) * (NW-1)'(mx5), 1'b0};
      dv[0].remy <= {(NW-1)'(n15) * (NW-1)'(my5), 1'b0};
      dv[0].qx   <= '0;
      dv[0].qy   <= '0;
    end
  end

  // restoring divider, one quotient bit per stage, most significant first
  for (genvar j = 0; j < QW; j++) begin : g_div
    localparam int K = QW - 1 - j;
    div_t          nx;
    logic [NW-1:0] dsh;

    always_comb begin
      nx  = dv[j];
      dsh = NW'(dv[j].det) << K;
      if (dv[j].remx >= dsh) begin
        nx.remx  = dv[j].remx - dsh;
        nx.qx[K] = 1'b1;
      end
      if (dv[j].remy >= dsh) begin
        nx.remy  = dv[j].remy - dsh;
        nx.qy[K] = 1'b1;
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[j+1].vld <= 1'b0;
      end else if (en) begin
        dv[j+1] <= nx;
      end
    end
  end

  // output register: round half away from zero, then offset from A
  logic [QW-1:0] rqx, rqy;
  logic [CW-1:0] ipx, ipy;

  always_comb begin
    rqx = (dv[QW].qx + QW'(1)) >> 1;
    rqy = (dv[QW].qy + QW'(1)) >> 1;
    ipx = dv[QW].negx ? dv[QW].bax - rqx[CW-1:0] : dv[QW].bax + rqx[CW-1:0];
    ipy = dv[QW].negy ? dv[QW].bay - rqy[CW-1:0] : dv[QW].bay + rqy[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_vld <= 1'b0;
    end else if (en) begin
      out_vld <= dv[QW].vld;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      out_hit <= dv[QW].hit;
      if (!dv[QW].hit) begin
        opx <= '0;
        opy <= '0;
      end else if (dv[QW].fix) begin
        opx <= dv[QW].fx;
        opy <= dv[QW].fy;
      end else begin
        opx <= ipx;
        opy <= ipy;
      end
    end
  end

endmodule
